### rtl/core/pstt_pkg.sv
package pstt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] KIND_FIRE      = 3'd0;
  localparam logic [2:0] KIND_TICK_DONE = 3'd1;
  localparam logic [2:0] KIND_ADD_OK    = 3'd2;
  localparam logic [2:0] KIND_ADD_FAIL  = 3'd3;
  localparam logic [2:0] KIND_REM_OK    = 3'd4;
  localparam logic [2:0] KIND_REM_FAIL  = 3'd5;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    logic [31:0] period;
    logic [31:0] remaining;
    logic [31:0] fired;
  } slot_entry_t;

  typedef struct packed {
    logic        we;
    slot_idx_t   waddr;
    slot_entry_t wdata;
    logic        re;
    slot_idx_t   raddr;
  } ram_req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [3:0]  timer_slot;
    logic [63:0] value;
    logic        last;
  } result_t;

endpackage

### rtl/core/pstt_if.sv
interface pstt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] interval;
  logic [3:0]  slot;

  modport source (output valid, output command, output interval, output slot, input ready);
  modport sink   (input valid, input command, input interval, input slot, output ready);
endinterface

interface pstt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [3:0]  timer_slot;
  logic [63:0] value;
  logic        last;

  modport source (output valid, output result_kind, output timer_slot, output value,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input timer_slot, input value,
                  input last, output ready);
endinterface

### rtl/core/pstt_slot_ram.sv
module pstt_slot_ram (
  input  logic                   clk,
  input  pstt_pkg::ram_req_t     req,
  output pstt_pkg::slot_entry_t  rd_data
);
  import pstt_pkg::*;

  slot_entry_t mem [SLOTS];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/pstt_ctrl.sv
module pstt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [31:0]           in_interval,
  input  logic [3:0]            in_slot,
  output pstt_pkg::ram_req_t    ram_req,
  input  pstt_pkg::slot_entry_t ram_rd,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pstt_pkg::result_t     res
);
  import pstt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_REM  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  slot_idx_t        idx_r, idx_nxt;
  logic [31:0]      interval_r, interval_nxt;
  logic [3:0]       slot_r, slot_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [SLOTS-1:0] del_r, del_nxt;
  logic [63:0]      tick_r, tick_nxt;

  logic             accept;
  logic             idx_last;
  slot_idx_t        rm_idx;
  logic             rm_ok;
  logic [31:0]      rem_dec;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign idx_last = (idx_r == SLOT_W'(SLOTS - 1));
  assign rm_idx   = SLOT_W'(slot_r);
  assign rm_ok    = (32'(slot_r) < SLOTS) && used_r[rm_idx] && !del_r[rm_idx];
  // shared decrement/compare unit, one slot per pass
  assign rem_dec  = ram_rd.remaining - 32'd1;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    interval_nxt = interval_r;
    slot_nxt     = slot_r;
    used_nxt     = used_r;
    del_nxt      = del_r;
    tick_nxt     = tick_r;
    ram_req      = '0;
    res_valid    = 1'b0;
    res          = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          interval_nxt = in_interval;
          slot_nxt     = in_slot;
          idx_nxt      = '0;
          case (in_command)
            CMD_TICK: begin
              tick_nxt  = tick_r + 64'd1;
              state_nxt = S_RD;
            end
            CMD_ADD:    state_nxt = S_ADD;
            CMD_REMOVE: state_nxt = S_REM;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end

      S_RD: begin
        if (used_r[idx_r]) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_r;
          state_nxt     = S_EVAL;
        end else if (idx_last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end

      S_EVAL: begin
        if (del_r[idx_r]) begin
          // free a deleted slot without firing
          used_nxt[idx_r] = 1'b0;
          del_nxt[idx_r]  = 1'b0;
          state_nxt       = idx_last ? S_DONE : S_RD;
          idx_nxt         = idx_last ? idx_r : idx_r + SLOT_W'(1);
        end else if (rem_dec == 32'd0) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_FIRE;
          res.timer_slot  = 4'(idx_r);
          res.value       = 64'(ram_rd.fired);
          res.last        = 1'b0;
          if (res_ready) begin
            ram_req.we              = 1'b1;
            ram_req.waddr           = idx_r;
            ram_req.wdata.period    = ram_rd.period;
            ram_req.wdata.remaining = ram_rd.period;
            ram_req.wdata.fired     = ram_rd.fired + 32'd1;
            state_nxt               = idx_last ? S_DONE : S_RD;
            idx_nxt                 = idx_last ? idx_r : idx_r + SLOT_W'(1);
          end
        end else begin
          ram_req.we              = 1'b1;
          ram_req.waddr           = idx_r;
          ram_req.wdata.period    = ram_rd.period;
          ram_req.wdata.remaining = rem_dec;
          ram_req.wdata.fired     = ram_rd.fired;
          state_nxt               = idx_last ? S_DONE : S_RD;
          idx_nxt                 = idx_last ? idx_r : idx_r + SLOT_W'(1);
        end
      end

      S_DONE: begin
        res_valid       = 1'b1;
        res.result_kind = KIND_TICK_DONE;
        res.value       = tick_r;
        res.last        = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_ADD: begin
        res.last = 1'b1;
        if (interval_r == 32'd0) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_ADD_FAIL;
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end else if (!used_r[idx_r]) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_ADD_OK;
          res.timer_slot  = 4'(idx_r);
          if (res_ready) begin
            ram_req.we              = 1'b1;
            ram_req.waddr           = idx_r;
            ram_req.wdata.period    = interval_r;
            ram_req.wdata.remaining = interval_r;
            ram_req.wdata.fired     = 32'd0;
            used_nxt[idx_r]         = 1'b1;
            del_nxt[idx_r]          = 1'b0;
            state_nxt               = S_IDLE;
          end
        end else if (idx_last) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_ADD_FAIL;
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end

      S_REM: begin
        res_valid       = 1'b1;
        res.result_kind = rm_ok ? KIND_REM_OK : KIND_REM_FAIL;
        res.timer_slot  = slot_r;
        res.last        = 1'b1;
        if (res_ready) begin
          if (rm_ok) begin
            del_nxt[rm_idx] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      used_r  <= '0;
      del_r   <= '0;
      tick_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      used_r  <= used_nxt;
      del_r   <= del_nxt;
      tick_r  <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    interval_r <= interval_nxt;
    slot_r     <= slot_nxt;
  end

  a_del_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
    (del_r & ~used_r) == '0)
    else $error("deleted slot not marked used");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("result offered while idle");

  a_tick_only_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_command != CMD_TICK) |=> $stable(tick_r))
    else $error("tick count moved without a tick");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == S_EVAL || state_r == S_ADD))
    else $error("slot store written outside eval or add");

  a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("slot store read and written in one cycle");

endmodule

### rtl/core/periodic_software_timer_table_core.sv
// A result beat is registered and appears on out_ch in the cycle after the sequencer
// hands it over. Tick: the accept, a read and an evaluate step per used slot and a
//   skip per free slot, then tick done, on the single decrement unit of the slot store.
// Add scans for a free slot. Results wait while out_ch stalls. One item at a time.
// Reset (rst_n low, synchronous): all slots free, tick count zero, no result pending.
module periodic_software_timer_table_core (
  input logic    clk,
  input logic    rst_n,
  pstt_in_if.sink    in_ch,
  pstt_out_if.source out_ch
);
  import pstt_pkg::*;

  ram_req_t    ram_req;
  slot_entry_t ram_rd;
  logic        res_valid;
  logic        res_ready;
  result_t     res;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_data_r;

  pstt_slot_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  pstt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_command  (in_ch.command),
    .in_interval (in_ch.interval),
    .in_slot     (in_ch.slot),
    .ram_req     (ram_req),
    .ram_rd      (ram_rd),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // take a new beat when the output register is empty or draining
  assign res_ready     = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_data_r.result_kind;
  assign out_ch.timer_slot  = out_data_r.timer_slot;
  assign out_ch.value       = out_data_r.value;
  assign out_ch.last        = out_data_r.last;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result beat changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !res_ready)
    else $error("result register overwritten while stalled");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready && res.last |=> in_ch.ready)
    else $error("block not idle after final result");

endmodule

### verif/pstt_checker.sv
module pstt_checker (
  input  logic clk,
  input  logic rst_n,
  pstt_in_if   in_mon,
  pstt_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   beats_seen,
  output int   fires_seen
);
  import pstt_pkg::*;

  logic [SLOTS-1:0] slot_live;
  logic [SLOTS-1:0] slot_dying;
  logic [31:0]      slot_period [SLOTS];
  logic [31:0]      slot_left   [SLOTS];
  logic [31:0]      slot_fires  [SLOTS];
  logic [63:0]      tick_total;

  result_t due_results [$];
  result_t want;
  result_t got;
  int      errors;
  int      beats;
  int      fires;

  function automatic void push_result(input logic [2:0] kind, input logic [3:0] sl,
                                      input logic [63:0] val, input logic fin);
    result_t r;
    r.result_kind = kind;
    r.timer_slot  = sl;
    r.value       = val;
    r.last        = fin;
    due_results.push_back(r);
  endfunction

  function automatic void advance_timer_table(input logic [1:0] cmd, input logic [31:0] ival,
                                              input logic [3:0] sl);
    bit placed;
    placed = 1'b0;
    case (cmd)
      CMD_TICK: begin
        tick_total = tick_total + 64'd1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) begin
            slot_left[i] = slot_left[i] - 32'd1;
            if (slot_dying[i]) begin
              slot_live[i]  = 1'b0;
              slot_dying[i] = 1'b0;
            end else if (slot_left[i] == 32'd0) begin
              push_result(KIND_FIRE, 4'(i), {32'd0, slot_fires[i]}, 1'b0);
              slot_fires[i] = slot_fires[i] + 32'd1;
              slot_left[i]  = slot_period[i];
            end
          end
        end
        push_result(KIND_TICK_DONE, 4'd0, tick_total, 1'b1);
      end
      CMD_ADD: begin
        if (ival != 32'd0) begin
          for (int i = 0; i < SLOTS && !placed; i++) begin
            if (!slot_live[i]) begin
              slot_live[i]   = 1'b1;
              slot_dying[i]  = 1'b0;
              slot_period[i] = ival;
              slot_left[i]   = ival;
              slot_fires[i]  = 32'd0;
              placed         = 1'b1;
              push_result(KIND_ADD_OK, 4'(i), 64'd0, 1'b1);
            end
          end
        end
        if (!placed) push_result(KIND_ADD_FAIL, 4'd0, 64'd0, 1'b1);
      end
      CMD_REMOVE: begin
        if (int'(sl) < SLOTS && slot_live[sl] && !slot_dying[sl]) begin
          slot_dying[sl] = 1'b1;
          push_result(KIND_REM_OK, sl, 64'd0, 1'b1);
        end else begin
          push_result(KIND_REM_FAIL, sl, 64'd0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_live  = '0;
      slot_dying = '0;
      tick_total = 64'd0;
      due_results.delete();
      errors = 0;
      beats  = 0;
      fires  = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        advance_timer_table(in_mon.command, in_mon.interval, in_mon.slot);
      if (out_mon.valid && out_mon.ready) begin
        got.result_kind = out_mon.result_kind;
        got.timer_slot  = out_mon.timer_slot;
        got.value       = out_mon.value;
        got.last        = out_mon.last;
        beats++;
        if (got.result_kind == KIND_FIRE) fires++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result beat kind %0d slot %0d value %0h last %0b",
                   $time, got.result_kind, got.timer_slot, got.value, got.last);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (got.result_kind !== want.result_kind) begin
            $display("%0t: result_kind expected %0d actual %0d",
                     $time, want.result_kind, got.result_kind);
            errors++;
          end
          if (got.timer_slot !== want.timer_slot) begin
            $display("%0t: timer_slot expected %0d actual %0d",
                     $time, want.timer_slot, got.timer_slot);
            errors++;
          end
          if (got.value !== want.value) begin
            $display("%0t: value expected %0h actual %0h", $time, want.value, got.value);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= due_results.size();
    beats_seen <= beats;
    fires_seen <= fires;
  end

endmodule

### verif/testbench.sv
module testbench;
  import pstt_pkg::*;

  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam int         MAX_CYCLES = 200000;
  localparam int         HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;

  pstt_in_if  in_ch();
  pstt_out_if out_ch();

  int fail_count;
  int pending;
  int beats_seen;
  int fires_seen;

  int send_idle;
  int recv_idle;
  bit hold_req;
  bit hold_done = 1'b0;
  int hold_left = HOLD_CYCLES;
  int cycles = 0;

  // occupancy as the sender sees it, used to aim removes at live slots
  logic [SLOTS-1:0] live_m;
  logic [SLOTS-1:0] dying_m;

  periodic_software_timer_table_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pstt_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .beats_seen (beats_seen),
    .fires_seen (fires_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        // long hold-off: let the block back up and stall its input
        out_ch.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] ival,
                           input logic [3:0] sl);
    bit placed;
    placed = 1'b0;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid    <= 1'b0;
      in_ch.command  <= 2'($urandom);
      in_ch.interval <= $urandom;
      in_ch.slot     <= 4'($urandom);
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.interval <= ival;
    in_ch.slot     <= sl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (cmd)
      CMD_TICK: begin
        live_m  = live_m & ~dying_m;
        dying_m = '0;
      end
      CMD_ADD: begin
        if (ival != 32'd0) begin
          for (int s = 0; s < SLOTS && !placed; s++) begin
            if (!live_m[s]) begin
              live_m[s] = 1'b1;
              placed    = 1'b1;
            end
          end
        end
      end
      CMD_REMOVE: if (live_m[sl] && !dying_m[sl]) dying_m[sl] = 1'b1;
      default: ;
    endcase
  endtask

  function automatic logic [3:0] pick_live();
    int n;
    int k;
    logic [3:0] r;
    r = 4'($urandom_range(15));
    n = $countones(live_m & ~dying_m);
    if (n > 0) begin
      k = $urandom_range(n - 1);
      for (int s = 0; s < SLOTS; s++) begin
        if (live_m[s] && !dying_m[s]) begin
          if (k == 0) r = 4'(s);
          k--;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_interval();
    int roll;
    logic [31:0] v;
    roll = $urandom_range(99);
    if (roll < 80)      v = $urandom_range(6, 1);
    else if (roll < 88) v = $urandom;
    else if (roll < 94) v = 32'd0;
    else                v = 32'hFFFF_FFFF;
    return v;
  endfunction

  task automatic run_random(input int n);
    int done_n;
    int roll;
    int add_top;
    done_n = 0;
    while (done_n < n) begin
      roll    = $urandom_range(99);
      add_top = ($countones(live_m) > 12) ? 70 : 80;
      if (roll < 3) begin
        send_item(CMD_NONE, $urandom, 4'($urandom));
      end else begin
        if (roll < 45)
          send_item(CMD_TICK, $urandom, 4'($urandom));
        else if (roll < add_top)
          send_item(CMD_ADD, pick_interval(), 4'($urandom));
        else if ($urandom_range(99) < 80)
          send_item(CMD_REMOVE, $urandom, pick_live());
        else
          send_item(CMD_REMOVE, $urandom, 4'($urandom));
        done_n++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_TICK;
    in_ch.interval = 32'd0;
    in_ch.slot     = 4'd0;
    send_idle      = 37;
    recv_idle      = 58;
    hold_req       = 1'b0;
    live_m         = '0;
    dying_m        = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, bad adds and removes, deletion freed on the tick
    send_item(CMD_TICK, 32'd0, 4'd0);
    send_item(CMD_REMOVE, 32'd0, 4'd15);
    send_item(CMD_ADD, 32'd0, 4'd0);
    send_item(CMD_ADD, 32'd1, 4'd0);
    send_item(CMD_ADD, 32'hFFFF_FFFF, 4'd15);
    send_item(CMD_NONE, 32'hFFFF_FFFF, 4'd15);
    send_item(CMD_TICK, 32'hFFFF_FFFF, 4'd15);
    send_item(CMD_REMOVE, 32'd0, 4'd1);
    send_item(CMD_REMOVE, 32'd0, 4'd1);
    send_item(CMD_TICK, 32'd0, 4'd0);
    send_item(CMD_REMOVE, 32'd0, 4'd1);
    // fill the table, overflow it, then fire every slot on one tick
    for (int s = 1; s < SLOTS; s++) send_item(CMD_ADD, 32'd1, 4'd0);
    send_item(CMD_ADD, 32'd5, 4'd0);
    send_item(CMD_TICK, 32'd0, 4'd0);
    send_item(CMD_REMOVE, 32'd0, 4'd15);
    send_item(CMD_REMOVE, 32'd0, 4'd0);

    run_random(100);
    send_idle <= 58;
    recv_idle <= 37;
    run_random(100);
    send_idle <= 0;
    recv_idle <= 0;
    hold_req  <= 1'b1;
    run_random(100);
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * SLOTS + 4) @(posedge clk);

    $display("covered %0d result beats with %0d fires over ~330 commands", beats_seen,
             fires_seen);
    $display("idle mixes 37/58, 58/37, none; one receiver hold of %0d cycles", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
